@@ src/sum_threshold_column_flagger_assert.svh @@
// Assertion macros for the column flagger.
`ifndef SUM_THRESHOLD_COLUMN_FLAGGER_ASSERT_SVH
`define SUM_THRESHOLD_COLUMN_FLAGGER_ASSERT_SVH
`ifndef SYNTHESIS
`define STF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define STF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define STF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define STF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ src/stf_pkg.sv @@
// Shared constants and types of the column flagger.
package stf_pkg;

  localparam int unsigned WINDOW_LEN  = 16;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned THRESHOLD_W = 31;
  localparam int unsigned ENTRY_W     = VALUE_W + 1;

  typedef struct packed {
    logic                       valid;
    logic                       push;
    logic                       pop;
    logic                       last;
    logic                       fwd;
    logic                       flag;
    logic signed [VALUE_W-1:0]  value;
  } stf_op_t;

  typedef struct packed {
    logic drain;
    logic empty;
  } stf_issue_status_t;

endpackage

@@ src/stf_if.sv @@
// Stream interfaces for samples in and flags out.
interface stf_sample_if;
  import stf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] sample_value;
  logic                      sample_flag;
  logic                      column_end;

  modport source (output valid, output sample_value, output sample_flag,
                  output column_end, input ready);
  modport sink (input valid, input sample_value, input sample_flag,
                input column_end, output ready);
endinterface

interface stf_result_if;
  logic valid;
  logic ready;
  logic out_flag;
  logic last_of_column;

  modport source (output valid, output out_flag, output last_of_column, input ready);
  modport sink (input valid, input out_flag, input last_of_column, output ready);
endinterface

@@ src/stf_ram.sv @@
// Generic single-port-write RAM with a registered read.
module stf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/stf_issue.sv @@
// Window pointer control: writes samples, issues reads of the oldest entry, drains columns.
module stf_issue import stf_pkg::*; #(
  parameter int unsigned WindowLen = WINDOW_LEN,
  localparam int unsigned AddrW = (WindowLen > 1) ? $clog2(WindowLen) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  stf_sample_if.sink        sample_i,
  input  logic              adv_i,
  output logic              ram_we_o,
  output logic [AddrW-1:0]  ram_waddr_o,
  output logic [ENTRY_W-1:0] ram_wdata_o,
  output logic              ram_re_o,
  output logic [AddrW-1:0]  ram_raddr_o,
  output stf_op_t           op_o,
  output stf_issue_status_t status_o
);

  localparam int unsigned FillW = $clog2(WindowLen + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(WindowLen - 1);
  localparam logic [FillW-1:0] FullFill = FillW'(WindowLen);

  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [FillW-1:0] fill_inc;
  logic             drain_q, drain_d;
  logic             accept;
  stf_op_t          op_q, op_d;

  function automatic logic [AddrW-1:0] ptr_next(input logic [AddrW-1:0] p);
    return (p == LastAddr) ? '0 : p + 1'b1;
  endfunction

  assign sample_i.ready = adv_i & ~drain_q;
  assign accept = sample_i.valid & sample_i.ready;
  assign fill_inc = fill_q + 1'b1;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d = fill_q;
    drain_d = drain_q;
    op_d = '0;
    op_d.value = sample_i.sample_value;
    op_d.flag = sample_i.sample_flag;
    if (accept) begin
      op_d.valid = 1'b1;
      op_d.push = 1'b1;
      wr_ptr_d = ptr_next(wr_ptr_q);
      fill_d = fill_inc;
      if (fill_inc == FullFill) begin
        op_d.pop = 1'b1;
        op_d.fwd = (rd_ptr_q == wr_ptr_q);
        rd_ptr_d = ptr_next(rd_ptr_q);
        fill_d = fill_q;
      end
      if (sample_i.column_end) begin
        if (fill_d == '0) begin
          op_d.last = 1'b1;
        end else begin
          drain_d = 1'b1;
        end
      end
    end else if (drain_q && adv_i) begin
      op_d.valid = 1'b1;
      op_d.pop = 1'b1;
      rd_ptr_d = ptr_next(rd_ptr_q);
      fill_d = fill_q - 1'b1;
      if (fill_q == FillW'(1)) begin
        op_d.last = 1'b1;
        drain_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q <= '0;
      drain_q <= 1'b0;
      op_q <= '0;
    end else if (adv_i) begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q <= fill_d;
      drain_q <= drain_d;
      op_q <= op_d;
    end
  end

  assign ram_we_o = accept;
  assign ram_waddr_o = wr_ptr_q;
  assign ram_wdata_o = {sample_i.sample_flag, sample_i.sample_value};
  assign ram_re_o = adv_i;
  assign ram_raddr_o = rd_ptr_q;
  assign op_o = op_q;
  assign status_o.drain = drain_q;
  assign status_o.empty = (fill_q == '0);

endmodule

@@ src/stf_window.sv @@
// Window sum, count and mean test, with the registered result output.
module stf_window import stf_pkg::*; #(
  parameter int unsigned WindowLen = WINDOW_LEN
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  stf_op_t                op_i,
  input  logic [ENTRY_W-1:0]     rdata_i,
  input  logic [THRESHOLD_W-1:0] threshold_i,
  stf_result_if.source           result_o,
  output logic                   adv_o
);

  localparam int unsigned CntW = $clog2(WindowLen + 1);
  localparam int unsigned SumW = VALUE_W + 1 + $clog2(WindowLen);
  localparam int unsigned LimW = THRESHOLD_W + CntW;
  localparam int unsigned CmpW = SumW + 1;
  localparam logic [CntW-1:0] FullCnt = CntW'(WindowLen);

  logic signed [SumW-1:0]    sum_q, sum_d, sum_add;
  logic [CntW-1:0]           count_q, count_d, count_add;
  logic [CntW-1:0]           forced_q, forced_d, forced_set;
  logic                      out_valid_q, out_valid_d;
  logic                      out_flag_q, out_flag_d;
  logic                      out_last_q, out_last_d;
  logic                      add_en;
  logic                      old_flag;
  logic signed [VALUE_W-1:0] old_value;
  logic [LimW-1:0]           limit;
  logic signed [CmpW-1:0]    sum_x, limit_x;
  logic                      hit;
  logic                      mark;

  assign adv_o = ~out_valid_q | result_o.ready;

  assign add_en = op_i.push & ~op_i.flag;
  assign sum_add = sum_q + (add_en ? SumW'(op_i.value) : '0);
  assign count_add = count_q + CntW'(add_en);
  assign old_flag = op_i.fwd ? op_i.flag : rdata_i[VALUE_W];
  assign old_value = op_i.fwd ? op_i.value : $signed(rdata_i[VALUE_W-1:0]);

  assign limit = LimW'(threshold_i) * LimW'(count_add);
  assign sum_x = CmpW'(sum_add);
  assign limit_x = CmpW'(limit);
  assign hit = (count_add != '0) && ((sum_x > limit_x) || (sum_x < -limit_x));
  assign forced_set = (op_i.push && op_i.pop && hit) ? FullCnt : forced_q;
  assign mark = (forced_set != '0);

  always_comb begin
    sum_d = sum_add;
    count_d = count_add;
    forced_d = forced_set;
    if (op_i.pop) begin
      if (mark) begin
        forced_d = forced_set - 1'b1;
      end
      if (!old_flag) begin
        sum_d = sum_add - SumW'(old_value);
        count_d = count_add - 1'b1;
      end
    end
    if (op_i.last) begin
      sum_d = '0;
      count_d = '0;
      forced_d = '0;
    end
    out_valid_d = op_i.valid & op_i.pop;
    out_flag_d = old_flag | mark;
    out_last_d = op_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      count_q <= '0;
      forced_q <= '0;
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      out_valid_q <= out_valid_d;
      if (op_i.valid) begin
        sum_q <= sum_d;
        count_q <= count_d;
        forced_q <= forced_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      out_flag_q <= out_flag_d;
      out_last_q <= out_last_d;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.out_flag = out_flag_q;
  assign result_o.last_of_column = out_last_q;

endmodule

@@ src/sum_threshold_column_flagger.sv @@
// Top level of the sliding-window sum-threshold column flagger.
//
//   Channel    Direction  Payload                                  Handshake
//   sample_i   in         sample_value, sample_flag, column_end    valid / ready
//   result_o   out        out_flag, last_of_column                 valid / ready
//   cfg        in         cfg_wdata_i (threshold)                  cfg_we_i
//
// One sample is taken per cycle unless a result stalls or a column drains; a result is
// registered in the issue op and window result registers after the transaction that releases it.
// The window lives in one RAM with a registered read, so the oldest entry is read into the
// RAM read register as a sample enters and retired from there by the window stage.
// A column end that leaves samples in the window holds off input until they are drained.
// Reset clears the pointers, counters, sums, flags and threshold but not the RAM; there is no clearing pass.
// A stalled result freezes both stages and the RAM read port.
`include "sum_threshold_column_flagger_assert.svh"

module sum_threshold_column_flagger import stf_pkg::*; #(
  parameter int unsigned WindowLen = WINDOW_LEN
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  stf_sample_if.sink             sample_i,
  stf_result_if.source           result_o,
  input  logic                   cfg_we_i,
  input  logic [THRESHOLD_W-1:0] cfg_wdata_i
);

  localparam int unsigned AddrW = (WindowLen > 1) ? $clog2(WindowLen) : 1;

  logic [THRESHOLD_W-1:0] threshold_q;
  logic                   adv;
  logic                   ram_we;
  logic [AddrW-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic                   ram_re;
  logic [AddrW-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]     ram_rdata;
  stf_op_t                op;
  stf_issue_status_t      issue_st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= '0;
    end else if (cfg_we_i) begin
      threshold_q <= cfg_wdata_i;
    end
  end

  stf_issue #(.WindowLen(WindowLen)) u_issue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_i),
    .adv_i       (adv),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .op_o        (op),
    .status_o    (issue_st)
  );

  stf_ram #(.Width(ENTRY_W), .Depth(WindowLen)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  stf_window #(.WindowLen(WindowLen)) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .rdata_i     (ram_rdata),
    .threshold_i (threshold_q),
    .result_o    (result_o),
    .adv_o       (adv)
  );

  `STF_ASSERT_IMP(a_drain_blocks_input, clk_i, rst_ni, issue_st.drain, !sample_i.ready, "input taken while draining")
  `STF_ASSERT_IMP(a_drain_not_empty, clk_i, rst_ni, issue_st.drain, !issue_st.empty, "draining an empty window")
  `STF_ASSERT_IMP(a_drain_ends_empty, clk_i, rst_ni, $fell(issue_st.drain), issue_st.empty, "drain ended with samples held")
  `STF_ASSERT_NXT(a_end_starts_drain, clk_i, rst_ni, sample_i.valid && sample_i.ready && sample_i.column_end, issue_st.drain || issue_st.empty, "column end left samples undrained")

endmodule

@@ tb/tb_sum_threshold_column_flagger.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the sliding-window sum-threshold column flagger.
module tb_sum_threshold_column_flagger;
  import stf_pkg::*;

  typedef struct packed {
    logic out_flag;
    logic last_of_column;
  } flag_result_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  localparam int unsigned LONG_HOLD     = 160;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned RESET_CYCLES  = 12;
  localparam logic [THRESHOLD_W-1:0] THRESHOLD_MAX = '1;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [THRESHOLD_W-1:0] cfg_wdata;

  stf_sample_if sample_bus ();
  stf_result_if result_bus ();

  sum_threshold_column_flagger u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .sample_i    (sample_bus),
    .result_o    (result_bus),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  logic signed [VALUE_W-1:0] held_value [WINDOW_LEN];
  logic                      held_flag  [WINDOW_LEN];
  longint                    run_sum;
  int                        run_count;
  int                        held_level;
  int                        marked_left;
  logic [THRESHOLD_W-1:0]    cur_threshold;
  flag_result_t              flag_q [$];
  flag_result_t              head_result;

  int       sent_count    = 0;
  int       column_count  = 0;
  int       checked_count = 0;
  int       flagged_count = 0;
  int       mismatch_count = 0;
  rx_mode_e rx_mode       = RX_ALWAYS;
  int       rx_phase      = 0;
  int       hold_id       = 0;
  int       hold_seen     = 0;
  int       hold_left     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("sum_threshold_column_flagger verification failed");
    $finish;
  end

  function automatic logic retire_oldest();
    logic fl;
    int   i;
    fl = held_flag[0] | (marked_left != 0);
    if (marked_left != 0) marked_left = marked_left - 1;
    if (!held_flag[0] && held_level != 0) begin
      run_sum = run_sum - held_value[0];
      if (run_count != 0) run_count = run_count - 1;
    end
    for (i = 1; i < held_level && i < WINDOW_LEN; i++) begin
      held_value[i-1] = held_value[i];
      held_flag[i-1]  = held_flag[i];
    end
    if (held_level != 0) held_level = held_level - 1;
    return fl;
  endfunction

  task automatic predict_window_flags(input logic signed [VALUE_W-1:0] v, input logic f,
                                      input logic e);
    logic         step_flag [WINDOW_LEN];
    int           n;
    int           k;
    longint       lim;
    flag_result_t r;
    n = 0;
    if (held_level >= WINDOW_LEN) held_level = WINDOW_LEN - 1;
    held_value[held_level] = v;
    held_flag[held_level]  = f;
    held_level = held_level + 1;
    if (!f) begin
      run_sum   = run_sum + v;
      run_count = run_count + 1;
    end
    if (held_level == WINDOW_LEN) begin
      lim = longint'(cur_threshold) * longint'(run_count);
      if (run_count != 0 && (run_sum > lim || run_sum < -lim))
        marked_left = WINDOW_LEN;
      step_flag[n] = retire_oldest();
      n++;
    end
    if (e) begin
      while (held_level != 0 && n < WINDOW_LEN) begin
        step_flag[n] = retire_oldest();
        n++;
      end
      run_sum     = 0;
      run_count   = 0;
      held_level  = 0;
      marked_left = 0;
      column_count++;
    end
    for (k = 0; k < n; k++) begin
      r.out_flag       = step_flag[k];
      r.last_of_column = e && (k == n - 1);
      flag_q.push_back(r);
    end
  endtask

  task automatic send_sample(input logic signed [VALUE_W-1:0] v, input logic f,
                             input logic e);
    @(negedge clk);
    sample_bus.valid        <= 1'b1;
    sample_bus.sample_value <= v;
    sample_bus.sample_flag  <= f;
    sample_bus.column_end   <= e;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    predict_window_flags(v, f, e);
    sent_count++;
  endtask

  task automatic pause_sender(input int cycles);
    @(negedge clk);
    sample_bus.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    sample_bus.valid <= 1'b0;
    while (flag_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THRESHOLD_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we        <= 1'b0;
    cur_threshold  = value;
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value(input longint level);
    int     mode;
    longint x;
    mode = $urandom_range(0, 9);
    if (mode < 6) x = level + longint'($urandom_range(0, 64)) - 32;
    else if (mode < 8) x = longint'($signed($urandom));
    else x = ($urandom_range(0, 1) != 0) ? 64'sd2147483647 : -64'sd2147483648;
    if (x > 64'sd2147483647) x = 64'sd2147483647;
    if (x < -64'sd2147483648) x = -64'sd2147483648;
    return x[VALUE_W-1:0];
  endfunction

  function automatic longint pick_level();
    longint lvl;
    case ($urandom_range(0, 3))
      0: lvl = 0;
      1: lvl = 2 * longint'(cur_threshold);
      default: lvl = longint'(cur_threshold);
    endcase
    return ($urandom_range(0, 1) != 0) ? -lvl : lvl;
  endfunction

  task automatic run_random_columns(input int n_items);
    int     left;
    int     len;
    int     flag_pct;
    int     burst;
    int     k;
    longint level;
    left  = n_items;
    burst = $urandom_range(1, 20);
    while (left > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 70) : $urandom_range(1, 24);
      if (len > left) len = left;
      case ($urandom_range(0, 9))
        0:       flag_pct = 100;
        1, 2:    flag_pct = 0;
        default: flag_pct = 15;
      endcase
      level = pick_level();
      for (k = 0; k < len; k++) begin
        send_sample(pick_value(level), $urandom_range(0, 99) < flag_pct, k == len - 1);
        burst--;
        if (burst == 0) begin
          pause_sender($urandom_range(1, 8));
          burst = $urandom_range(1, 30);
        end
      end
      left -= len;
    end
  endtask

  task automatic test_short_columns();
    write_threshold('0);
    rx_mode = RX_ALWAYS;
    send_sample(32'sh7FFF_FFFF, 1'b0, 1'b0);
    send_sample(32'sh8000_0000, 1'b1, 1'b0);
    send_sample(32'sh0000_0001, 1'b0, 1'b1);
    send_sample(32'sh0000_0000, 1'b0, 1'b1);
    drain_results();
  endtask

  task automatic test_empty_count();
    int k;
    rx_mode = RX_PERIODIC;
    for (k = 0; k < WINDOW_LEN; k++)
      send_sample(k[0] ? 32'sh8000_0000 : 32'sh7FFF_FFFF, 1'b1, 1'b0);
    send_sample(32'sh0000_0000, 1'b0, 1'b0);
    send_sample(32'sh0000_0000, 1'b0, 1'b0);
    send_sample(32'sh0000_0000, 1'b0, 1'b1);
    drain_results();
  endtask

  task automatic test_threshold_sweep();
    logic [THRESHOLD_W-1:0] settings [5];
    int                     p;
    settings[0] = '0;
    settings[1] = THRESHOLD_MAX;
    settings[2] = THRESHOLD_W'($urandom_range(32'h100, 32'h4_0000));
    settings[3] = THRESHOLD_W'($urandom_range(0, 32'h7FFF_FFFF));
    settings[4] = THRESHOLD_W'(32'h1_0000);
    for (p = 0; p < 5; p++) begin
      write_threshold(settings[p]);
      rx_mode = rx_mode_e'(p % 3);
      run_random_columns(32);
      drain_results();
    end
  endtask

  task automatic test_backpressure();
    int     k;
    longint level;
    write_threshold(THRESHOLD_W'(32'h8000));
    rx_mode = RX_RANDOM;
    level   = pick_level();
    hold_id++;
    for (k = 0; k < 30; k++)
      send_sample(pick_value(level), $urandom_range(0, 9) == 0, 1'b0);
    drain_results();
    for (k = 0; k < 18; k++)
      send_sample(pick_value(level), $urandom_range(0, 9) == 0, k == 17);
    drain_results();
  endtask

  always @(negedge clk) begin
    rx_phase++;
    if (hold_id != hold_seen) begin
      hold_seen = hold_id;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_bus.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_RANDOM:   result_bus.ready <= ($urandom_range(0, 99) < 70);
        RX_PERIODIC: result_bus.ready <= ((rx_phase % 9) > 2);
        default:     result_bus.ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && result_bus.valid && result_bus.ready) begin
      if (flag_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: out_flag %0b last_of_column %0b",
                   result_bus.out_flag, result_bus.last_of_column);
      end else begin
        head_result = flag_q.pop_front();
        checked_count++;
        if (head_result.out_flag) flagged_count++;
        if (result_bus.out_flag !== head_result.out_flag ||
            result_bus.last_of_column !== head_result.last_of_column) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result %0d mismatch: expected out_flag %0b last %0b, got %0b %0b",
                     checked_count, head_result.out_flag, head_result.last_of_column,
                     result_bus.out_flag, result_bus.last_of_column);
        end
      end
    end
  end

  initial begin
    rst_n                   <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_wdata               <= '0;
    sample_bus.valid        <= 1'b0;
    sample_bus.sample_value <= '0;
    sample_bus.sample_flag  <= 1'b0;
    sample_bus.column_end   <= 1'b0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      held_value[i] = '0;
      held_flag[i]  = 1'b0;
    end
    run_sum       = 0;
    run_count     = 0;
    held_level    = 0;
    marked_left   = 0;
    cur_threshold = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_short_columns();
    test_empty_count();
    test_threshold_sweep();
    test_backpressure();
    drain_results();

    $display("Checked %0d flag results from %0d samples in %0d columns, %0d flagged.",
             checked_count, sent_count, column_count, flagged_count);
    $display("Thresholds from zero to full scale, a long result hold-off and a mid-column pause.");
    if (mismatch_count == 0) begin
      $display("sum_threshold_column_flagger verification clean");
    end else begin
      $display("sum_threshold_column_flagger verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/stf_pkg.sv
src/stf_if.sv
src/stf_ram.sv
src/stf_issue.sv
src/stf_window.sv
src/sum_threshold_column_flagger.sv
tb/tb_sum_threshold_column_flagger.sv
